/* rtl/core/brz_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the bilinear image resizer
// no dependencies

package brz_pkg;

    localparam int BRZ_MAX_WIDTH  = 512;
    localparam int BRZ_MAX_HEIGHT = 512;
    localparam int BRZ_FRAC_BITS  = 8;

    localparam int COORD_W    = 10;
    localparam int PIX_W      = 8;
    localparam int IN_SZ_W    = 10;
    localparam int OUT_SZ_W   = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    localparam logic [IN_SZ_W-1:0]  RST_IN_SIZE  = IN_SZ_W'(512);
    localparam logic [OUT_SZ_W-1:0] RST_OUT_SIZE = OUT_SZ_W'(512);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_WIDTH   = 2'd0,
        CFG_IN_HEIGHT  = 2'd1,
        CFG_OUT_WIDTH  = 2'd2,
        CFG_OUT_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_REQUEST = 1'b1
    } t_op;

    // item fields carried alongside the position dividers
    typedef struct packed {
        logic               vld;
        t_op                op;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   pix;
    } t_sb;

endpackage

/* rtl/core/brz_div.sv */
`timescale 1ns / 1ps
// fully pipelined restoring divider, one quotient bit per stage
// no dependencies

module brz_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 11
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_nq  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] nq_in;
        logic [DEN_W:0]   trial;
        logic             take;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = i_num;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign nq_in  = r_nq[k-1];
        end

        assign trial = {rem_in, nq_in[NUM_W-1]};
        assign take  = (trial >= {1'b0, i_den});

        // numerator bits shift out the top while quotient bits shift in
        always_ff @(posedge i_clk) begin
            r_rem[k] <= take ? DEN_W'(trial - {1'b0, i_den}) : trial[DEN_W-1:0];
            r_nq[k]  <= {nq_in[NUM_W-2:0], take};
        end
    end

    assign o_quo = r_nq[NUM_W-1];

endmodule

/* rtl/core/bilinear_image_resizer_unit.sv */
`timescale 1ns / 1ps
// bilinear grayscale scaler: top level with banked frame store
// depends on brz_pkg and brz_div

// Takes one beat per clock, loads and requests mixed freely; busy is high
// during reset and up to the first clock edge after it. A load writes one
// source pixel, a request returns one scaled pixel strobed on
// o_valid/o_pixel_out after passing the capture stage, the bit-per-stage
// position dividers and stages 1 to 5, in that order. Results come out in
// request order and are shown for one cycle only: the receiver cannot stall.
// Loads travel the same pipeline and write the frame store at the stage where
// requests read it, so every request sees exactly the loads taken before it.
// The store is split into four banks by column and row parity so all four
// neighbours are read in the same cycle. Configuration may be written only
// while no beats are in flight.

module bilinear_image_resizer_unit
    import brz_pkg::*;
#(
    parameter int MAX_WIDTH  = BRZ_MAX_WIDTH,
    parameter int MAX_HEIGHT = BRZ_MAX_HEIGHT,
    parameter int FRAC_BITS  = BRZ_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_operation,
    input  logic [COORD_W-1:0]    i_column,
    input  logic [COORD_W-1:0]    i_row,
    input  logic [PIX_W-1:0]      i_pixel_in,
    output logic                  o_valid,
    output logic [PIX_W-1:0]      o_pixel_out
);

    localparam int PROD_W = COORD_W + IN_SZ_W;
    localparam int NUM_W  = PROD_W + FRAC_BITS;
    localparam int ONE_W  = FRAC_BITS + 1;
    localparam int WGT_W  = 2 * FRAC_BITS + 1;
    localparam int MUL_W  = WGT_W + PIX_W;
    localparam int SUM_W  = MUL_W + 2;
    localparam int HALF_W = (MAX_WIDTH + 1) / 2;
    localparam int HALF_H = (MAX_HEIGHT + 1) / 2;
    localparam int DEPTH  = HALF_W * HALF_H;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LAT    = NUM_W + 6;
    localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FRAC_BITS;

    // configuration registers
    logic [IN_SZ_W-1:0]  r_in_width, r_in_height;
    logic [OUT_SZ_W-1:0] r_out_width, r_out_height;
    logic                r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width   <= RST_IN_SIZE;
            r_in_height  <= RST_IN_SIZE;
            r_out_width  <= RST_OUT_SIZE;
            r_out_height <= RST_OUT_SIZE;
            r_busy       <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_IN_WIDTH:   r_in_width   <= i_cfg_data[IN_SZ_W-1:0];
                    CFG_IN_HEIGHT:  r_in_height  <= i_cfg_data[IN_SZ_W-1:0];
                    CFG_OUT_WIDTH:  r_out_width  <= i_cfg_data;
                    CFG_OUT_HEIGHT: r_out_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign busy = r_busy;

    // effective sizes: zero acts as one, source sizes capped at the store
    logic [IN_SZ_W-1:0]  iw, ih;
    logic [OUT_SZ_W-1:0] ow, oh;

    always_comb begin
        if (r_in_width == '0) begin
            iw = IN_SZ_W'(1);
        end else if (int'(r_in_width) > MAX_WIDTH) begin
            iw = IN_SZ_W'(MAX_WIDTH);
        end else begin
            iw = r_in_width;
        end
        if (r_in_height == '0) begin
            ih = IN_SZ_W'(1);
        end else if (int'(r_in_height) > MAX_HEIGHT) begin
            ih = IN_SZ_W'(MAX_HEIGHT);
        end else begin
            ih = r_in_height;
        end
        ow = (r_out_width == '0) ? OUT_SZ_W'(1) : r_out_width;
        oh = (r_out_height == '0) ? OUT_SZ_W'(1) : r_out_height;
    end

    // stage 0: capture beat, scale coordinate by source size
    logic              accept;
    t_sb               r_s0;
    logic [PROD_W-1:0] r_s0_px, r_s0_py;

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.vld <= 1'b0;
        end else begin
            r_s0.vld <= accept;
            r_s0.op  <= t_op'(i_operation);
            r_s0.col <= i_column;
            r_s0.row <= i_row;
            r_s0.pix <= i_pixel_in;
        end
        r_s0_px <= PROD_W'(i_column) * PROD_W'(iw);
        r_s0_py <= PROD_W'(i_row) * PROD_W'(ih);
    end

    // position dividers, x and y side by side
    logic [NUM_W-1:0] qx, qy;

    brz_div #(.NUM_W(NUM_W), .DEN_W(OUT_SZ_W)) u_div_x (
        .i_clk (i_clk),
        .i_num ({r_s0_px, {FRAC_BITS{1'b0}}}),
        .i_den (ow),
        .o_quo (qx)
    );

    brz_div #(.NUM_W(NUM_W), .DEN_W(OUT_SZ_W)) u_div_y (
        .i_clk (i_clk),
        .i_num ({r_s0_py, {FRAC_BITS{1'b0}}}),
        .i_den (oh),
        .o_quo (qy)
    );

    // item fields follow the divider stages
    t_sb r_sb [NUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_W; k++) begin
                r_sb[k].vld <= 1'b0;
            end
        end else begin
            r_sb[0] <= r_s0;
            for (int k = 1; k < NUM_W; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // stage 1: integer part clamped to the image, neighbour clamped too
    t_sb                  r_s1;
    logic [COORD_W-1:0]   r_s1_x0, r_s1_x1, r_s1_y0, r_s1_y1;
    logic [FRAC_BITS-1:0] r_s1_p, r_s1_a;
    logic [PROD_W-1:0]    ix, iy;
    logic [COORD_W-1:0]   n_x0, n_x1, n_y0, n_y1;
    logic [COORD_W:0]     x0_inc, y0_inc;

    assign ix = qx[NUM_W-1:FRAC_BITS];
    assign iy = qy[NUM_W-1:FRAC_BITS];

    always_comb begin
        n_x0   = (ix >= PROD_W'(iw)) ? COORD_W'(iw - 1'b1) : ix[COORD_W-1:0];
        n_y0   = (iy >= PROD_W'(ih)) ? COORD_W'(ih - 1'b1) : iy[COORD_W-1:0];
        x0_inc = {1'b0, n_x0} + 1'b1;
        y0_inc = {1'b0, n_y0} + 1'b1;
        n_x1   = (x0_inc >= (COORD_W+1)'(iw)) ? COORD_W'(iw - 1'b1) : x0_inc[COORD_W-1:0];
        n_y1   = (y0_inc >= (COORD_W+1)'(ih)) ? COORD_W'(ih - 1'b1) : y0_inc[COORD_W-1:0];
        // a load addresses its own pixel through the same bank logic
        if (r_sb[NUM_W-1].op == OP_LOAD) begin
            n_x0 = r_sb[NUM_W-1].col;
            n_x1 = r_sb[NUM_W-1].col;
            n_y0 = r_sb[NUM_W-1].row;
            n_y1 = r_sb[NUM_W-1].row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else begin
            r_s1 <= r_sb[NUM_W-1];
        end
        r_s1_x0 <= n_x0;
        r_s1_x1 <= n_x1;
        r_s1_y0 <= n_y0;
        r_s1_y1 <= n_y1;
        r_s1_p  <= qx[FRAC_BITS-1:0];
        r_s1_a  <= qy[FRAC_BITS-1:0];
    end

    // stage 2: bank addresses, write enables, bilinear weights
    logic                 r_s2_rd;
    logic [3:0]           r_s2_we;
    logic [PIX_W-1:0]     r_s2_pix;
    logic [AW-1:0]        r_s2_addr [4];
    logic [1:0]           r_s2_nb   [4];
    logic [WGT_W-1:0]     r_s2_w    [4];
    logic                 ld_in_range;
    logic [ONE_W-1:0]     wp0, wa0;

    assign ld_in_range = (int'(r_s1_x0) < MAX_WIDTH) && (int'(r_s1_y0) < MAX_HEIGHT);
    assign wp0 = ONE - {1'b0, r_s1_p};
    assign wa0 = ONE - {1'b0, r_s1_a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_rd <= 1'b0;
            r_s2_we <= '0;
        end else begin
            r_s2_rd <= r_s1.vld && (r_s1.op == OP_REQUEST);
            for (int b = 0; b < 4; b++) begin
                r_s2_we[b] <= r_s1.vld && (r_s1.op == OP_LOAD) && ld_in_range
                              && (2'(b) == {r_s1_y0[0], r_s1_x0[0]});
            end
        end
        r_s2_pix <= r_s1.pix;
    end

    for (genvar b = 0; b < 4; b++) begin : g_addr
        logic [COORD_W-1:0] cx, cy;

        assign cx = (r_s1_x0[0] == 1'(b % 2)) ? r_s1_x0 : r_s1_x1;
        assign cy = (r_s1_y0[0] == 1'(b / 2)) ? r_s1_y0 : r_s1_y1;

        always_ff @(posedge i_clk) begin
            r_s2_addr[b] <= AW'(int'(cy[COORD_W-1:1]) * HALF_W + int'(cx[COORD_W-1:1]));
        end
    end

    // neighbour n: bit 0 picks the right column, bit 1 the lower row
    for (genvar n = 0; n < 4; n++) begin : g_wgt
        logic [ONE_W-1:0] wx, wy;
        logic             nb_y, nb_x;

        assign wx   = (n % 2 == 1) ? {1'b0, r_s1_p} : wp0;
        assign wy   = (n / 2 == 1) ? {1'b0, r_s1_a} : wa0;
        assign nb_y = (n / 2 == 1) ? r_s1_y1[0] : r_s1_y0[0];
        assign nb_x = (n % 2 == 1) ? r_s1_x1[0] : r_s1_x0[0];

        always_ff @(posedge i_clk) begin
            r_s2_w[n]  <= WGT_W'(wx) * WGT_W'(wy);
            r_s2_nb[n] <= {nb_y, nb_x};
        end
    end

    // stage 3: frame store banks, write or registered read
    logic                 r_s3_vld;
    logic [PIX_W-1:0]     r_s3_data [4];
    logic [1:0]           r_s3_nb   [4];
    logic [WGT_W-1:0]     r_s3_w    [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [PIX_W-1:0] mem [DEPTH];

        always_ff @(posedge i_clk) begin
            if (r_s2_we[b]) begin
                mem[r_s2_addr[b]] <= r_s2_pix;
            end
            r_s3_data[b] <= mem[r_s2_addr[b]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_rd;
        end
        r_s3_nb <= r_s2_nb;
        r_s3_w  <= r_s2_w;
    end

    // stage 4: weight times neighbour pixel
    logic             r_s4_vld;
    logic [MUL_W-1:0] r_s4_prod [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
        for (int n = 0; n < 4; n++) begin
            r_s4_prod[n] <= MUL_W'(r_s3_w[n]) * MUL_W'(r_s3_data[r_s3_nb[n]]);
        end
    end

    // stage 5: sum and truncate to the output pixel
    logic [SUM_W-1:0] sum;

    assign sum = SUM_W'(r_s4_prod[0]) + SUM_W'(r_s4_prod[1])
               + SUM_W'(r_s4_prod[2]) + SUM_W'(r_s4_prod[3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_s4_vld;
        end
        o_pixel_out <= sum[2*FRAC_BITS +: PIX_W];
    end

    // every result traces back to an accepted request
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && (i_operation == OP_REQUEST), LAT))
        else $error("result without matching request");

    // a load writes at most one bank
    a_one_bank_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_s2_we))
        else $error("load hits more than one bank");

    // one beat per stage: never a read and a write in the same cycle
    a_no_rd_wr_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_rd |-> (r_s2_we == '0))
        else $error("store read and write collide");

    // right neighbour is the same column or the next one
    a_neighbour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1.vld && (r_s1.op == OP_REQUEST)) |->
        ((r_s1_x1 == r_s1_x0) || ({1'b0, r_s1_x1} == {1'b0, r_s1_x0} + 1'b1)))
        else $error("neighbour column out of order");

endmodule

/* bench/brz_scoreboard.sv */
`timescale 1ns / 1ps
// scoreboard for the bilinear image resizer: mirrors the frame store and sizes
// depends on brz_pkg

module brz_scoreboard
    import brz_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic                  i_operation,
    input  logic [COORD_W-1:0]    i_column,
    input  logic [COORD_W-1:0]    i_row,
    input  logic [PIX_W-1:0]      i_pixel_in,
    input  logic                  i_valid,
    input  logic [PIX_W-1:0]      i_pixel_out,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic [PIX_W-1:0]    src_image [0:BRZ_MAX_WIDTH*BRZ_MAX_HEIGHT-1];
    logic [IN_SZ_W-1:0]  in_w, in_h;
    logic [OUT_SZ_W-1:0] out_w, out_h;
    logic [PIX_W-1:0]    pending_pixels [$];

    function automatic longint unsigned eff_in(logic [IN_SZ_W-1:0] v, int lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic longint unsigned edge_clamp(longint unsigned v, longint unsigned n);
        return (v >= n) ? n - 1 : v;
    endfunction

    function automatic logic [PIX_W-1:0] interpolate_pixel(logic [COORD_W-1:0] col,
                                                           logic [COORD_W-1:0] row);
        longint unsigned iw, ih, ow, oh, one, px, py, p, a, x0, y0, x1, y1, sum;
        iw  = eff_in(in_w, BRZ_MAX_WIDTH);
        ih  = eff_in(in_h, BRZ_MAX_HEIGHT);
        ow  = (out_w == 0) ? 1 : out_w;
        oh  = (out_h == 0) ? 1 : out_h;
        one = 1 << BRZ_FRAC_BITS;
        px  = ((col * iw) << BRZ_FRAC_BITS) / ow;
        py  = ((row * ih) << BRZ_FRAC_BITS) / oh;
        p   = px & (one - 1);
        a   = py & (one - 1);
        x0  = edge_clamp(px >> BRZ_FRAC_BITS, iw);
        y0  = edge_clamp(py >> BRZ_FRAC_BITS, ih);
        x1  = edge_clamp(x0 + 1, iw);
        y1  = edge_clamp(y0 + 1, ih);
        sum = (one - p) * (one - a) * src_image[y0 * BRZ_MAX_WIDTH + x0]
            + (one - p) * a * src_image[y1 * BRZ_MAX_WIDTH + x0]
            + p * (one - a) * src_image[y0 * BRZ_MAX_WIDTH + x1]
            + p * a * src_image[y1 * BRZ_MAX_WIDTH + x1];
        return PIX_W'(sum >> (2 * BRZ_FRAC_BITS));
    endfunction

    assign o_pending = pending_pixels.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_w  <= RST_IN_SIZE;
            in_h  <= RST_IN_SIZE;
            out_w <= RST_OUT_SIZE;
            out_h <= RST_OUT_SIZE;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_IN_WIDTH:   in_w  <= IN_SZ_W'(i_cfg_data);
                    CFG_IN_HEIGHT:  in_h  <= IN_SZ_W'(i_cfg_data);
                    CFG_OUT_WIDTH:  out_w <= i_cfg_data;
                    CFG_OUT_HEIGHT: out_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                if (t_op'(i_operation) == OP_LOAD) begin
                    if (i_column < BRZ_MAX_WIDTH && i_row < BRZ_MAX_HEIGHT)
                        src_image[i_row * BRZ_MAX_WIDTH + i_column] = i_pixel_in;
                end else begin
                    pending_pixels.push_back(interpolate_pixel(i_column, i_row));
                end
            end
            if (i_valid) begin
                if (pending_pixels.size() == 0) begin
                    $error("pixel_out: unexpected beat, value %0d", i_pixel_out);
                    o_fail_count <= o_fail_count + 1;
                end else if (pending_pixels[0] !== i_pixel_out) begin
                    $error("pixel_out: expected %0d, actual %0d",
                           pending_pixels[0], i_pixel_out);
                    o_fail_count <= o_fail_count + 1;
                    void'(pending_pixels.pop_front());
                end else begin
                    void'(pending_pixels.pop_front());
                end
            end
        end
    end

endmodule

/* bench/bilinear_image_resizer_unit_test.sv */
`timescale 1ns / 1ps
// testbench top for the bilinear image resizer: stimulus, watchdog, verdict
// depends on brz_pkg, brz_scoreboard and bilinear_image_resizer_unit

module bilinear_image_resizer_unit_test;
    import brz_pkg::*;

    localparam int DRAIN_CYCLES = 40;   // longer than the pipeline takes to empty
    localparam int IDLE_LIMIT   = 3000; // cycles without any accepted beat, result, register write or reset
    localparam int ITEM_TARGET  = 1850;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_IN_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_operation = OP_LOAD;
    logic [COORD_W-1:0]    i_column = '0;
    logic [COORD_W-1:0]    i_row = '0;
    logic [PIX_W-1:0]      i_pixel_in = '0;
    logic                  o_valid;
    logic [PIX_W-1:0]      o_pixel_out;
    int                    fail_count, pending;

    int n_items, n_loads, n_requests, n_phases, burst_left;
    int img_w, img_h, scl_w, scl_h; // effective sizes of the current setting

    always #2 i_clk = ~i_clk;

    bilinear_image_resizer_unit i_dut (.*);

    brz_scoreboard i_scoreboard (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_start(start), .i_busy(busy), .i_operation, .i_column, .i_row,
        .i_pixel_in, .i_valid(o_valid), .i_pixel_out(o_pixel_out),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog: any accepted beat, result, register write or reset counts as progress
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || i_cfg_we || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("** bilinear_image_resizer_unit: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one beat; start stays high inside a burst, gaps fall between bursts
    task automatic send_beat(t_op op, int col, int row, int pix);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0 && start) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        start       <= 1'b1;
        i_operation <= op;
        i_column    <= COORD_W'(col);
        i_row       <= COORD_W'(row);
        i_pixel_in  <= PIX_W'(pix);
        // busy only moves at a rising edge, so the falling edge sees it settled
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        n_items++;
        if (op == OP_LOAD) n_loads++;
        else n_requests++;
    endtask

    // stop sending and let every request come back, then cover trailing loads
    task automatic drain_pipe();
        start <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_sizes(int iw, int ih, int ow, int oh);
        drain_pipe();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_IN_WIDTH;   i_cfg_data <= CFG_DATA_W'(iw); @(posedge i_clk);
        i_cfg_index <= CFG_IN_HEIGHT;  i_cfg_data <= CFG_DATA_W'(ih); @(posedge i_clk);
        i_cfg_index <= CFG_OUT_WIDTH;  i_cfg_data <= CFG_DATA_W'(ow); @(posedge i_clk);
        i_cfg_index <= CFG_OUT_HEIGHT; i_cfg_data <= CFG_DATA_W'(oh); @(posedge i_clk);
        i_cfg_we <= 1'b0;
        // sizes as the block sees them: zero acts as one, big sources saturate
        img_w = (iw == 0) ? 1 : (iw > BRZ_MAX_WIDTH) ? BRZ_MAX_WIDTH : iw;
        img_h = (ih == 0) ? 1 : (ih > BRZ_MAX_HEIGHT) ? BRZ_MAX_HEIGHT : ih;
        scl_w = (ow == 0) ? 1 : ow;
        scl_h = (oh == 0) ? 1 : oh;
        n_phases++;
        // fill the whole source region so no request reads an unwritten pixel,
        // with an occasional load outside the store that must be dropped
        for (int y = 0; y < img_h; y++) begin
            for (int x = 0; x < img_w; x++) begin
                if ($urandom_range(0, 19) == 0)
                    send_beat(OP_LOAD, $urandom_range(BRZ_MAX_WIDTH, 1023),
                              $urandom_range(0, 1023), $urandom_range(0, 255));
                send_beat(OP_LOAD, x, y, $urandom_range(0, 255));
            end
        end
    endtask

    // output coordinate mostly near the scaled size, sometimes anywhere
    function automatic int pick_coord(int lim);
        int hi;
        hi = (lim + 1 > 1023) ? 1023 : lim + 1;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, hi);
    endfunction

    task automatic random_traffic(int beats);
        int r;
        for (int k = 0; k < beats; k++) begin
            r = $urandom_range(0, 99);
            if (r < 75)
                send_beat(OP_REQUEST, pick_coord(scl_w), pick_coord(scl_h),
                          $urandom_range(0, 255));
            else if (r < 93)
                send_beat(OP_LOAD, $urandom_range(0, img_w - 1),
                          $urandom_range(0, img_h - 1), $urandom_range(0, 255));
            else
                send_beat(OP_LOAD, $urandom_range(0, 1023),
                          $urandom_range(BRZ_MAX_HEIGHT, 1023), $urandom_range(0, 255));
        end
    endtask

    initial begin
        int iw, ih, ow, oh;
        n_items = 0; n_loads = 0; n_requests = 0; n_phases = 0; burst_left = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero sizes: one source pixel, every request reads it
        set_sizes(0, 0, 0, 0);
        send_beat(OP_REQUEST, 0, 0, 0);
        send_beat(OP_REQUEST, 1023, 1023, 255);
        send_beat(OP_REQUEST, 512, 1, 0);

        // oversized source width, widest output field, one source row
        set_sizes(1023, 1, 2047, 1);
        send_beat(OP_REQUEST, 0, 0, 0);
        send_beat(OP_REQUEST, 1023, 0, 0);
        send_beat(OP_REQUEST, 511, 1023, 0);
        send_beat(OP_REQUEST, 1, 0, 0);

        // tall single column, output height 1024, and past the image
        set_sizes(1, 1023, 1, 1024);
        send_beat(OP_REQUEST, 0, 1023, 0);
        send_beat(OP_REQUEST, 0, 1022, 0);
        send_beat(OP_REQUEST, 1023, 0, 0);
        send_beat(OP_REQUEST, 0, 511, 0);

        // small upscale of a square source: fractions, edge neighbours, beyond the output size
        set_sizes(3, 3, 7, 5);
        for (int k = 0; k < 8; k++)
            send_beat(OP_REQUEST, k, k % 6, 0);
        send_beat(OP_REQUEST, 1023, 1023, 0);
        send_beat(OP_LOAD, 1023, 1023, 255); // ignored, outside the store
        send_beat(OP_REQUEST, 6, 4, 0);

        // random settings, mostly small images, now and then an extreme
        while (n_items < ITEM_TARGET) begin
            iw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) * 1023
                                             : $urandom_range(1, 12);
            ih = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            ow = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 2047 : 0)
                                             : $urandom_range(1, 40);
            oh = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 1024 : 0)
                                             : $urandom_range(1, 40);
            if (iw == 1023) ih = ($urandom_range(0, 1)) ? 0 : 1; // keep the fill short
            set_sizes(iw, ih, ow, oh);
            random_traffic($urandom_range(30, 80));
        end

        drain_pipe();
        $display("covered %0d beats (%0d loads, %0d requests) over %0d size settings",
                 n_items, n_loads, n_requests, n_phases);
        if (fail_count == 0) begin
            $display("** bilinear_image_resizer_unit: PASSED **");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("** bilinear_image_resizer_unit: FAILED **");
        end
        $finish;
    end

endmodule
